### design/assert_macros.svh
// assertion macros for the design files, used by the transceiver core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, masked while in reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/uart_trx_pkg.sv
// shared types and constants for the uart transceiver
`default_nettype none

package uart_trx_pkg;

    // transmit queue geometry
    localparam int TXQ_DEPTH = 16;
    localparam int TXQ_AW    = $clog2(TXQ_DEPTH);
    localparam int TXQ_CW    = $clog2(TXQ_DEPTH + 1);

    // bit period counter and register port widths
    localparam int BAUD_W = 24;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // limits of the character format registers
    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX = 4'd8;
    localparam logic [1:0] STOP_BITS_MIN = 2'd1;
    localparam logic [1:0] STOP_BITS_MAX = 2'd2;

    // frame phase of both the receiver and the transmitter
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_PARITY,
        PH_STOP
    } phase_t;

    // register map, word index
    typedef enum logic [2:0] {
        REG_BAUD      = 3'd0,
        REG_DATA_BITS = 3'd1,
        REG_STOP_BITS = 3'd2,
        REG_PAR_EN    = 3'd3,
        REG_PAR_EVEN  = 3'd4
    } cfg_reg_t;

    // queue control from the core
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } txq_req_t;

    // queue fill status to the core
    typedef struct packed {
        logic empty;
        logic full;
    } txq_status_t;

    // one result request
    typedef struct packed {
        logic       line_out;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_frame_error;
        logic       send_dropped;
    } result_t;

endpackage

`default_nettype wire

### design/uart_trx_tick_if.sv
// channel carrying one line sample and an optional byte to send
`default_nettype none

interface uart_trx_tick_if;
    logic       valid;
    logic       ready;
    logic       line_in;
    logic       send_valid;
    logic [7:0] send_byte;

    modport source (output valid, line_in, send_valid, send_byte, input ready);
    modport sink   (input valid, line_in, send_valid, send_byte, output ready);
endinterface

`default_nettype wire

### design/uart_trx_result_if.sv
// channel carrying the per-tick line and receive status
`default_nettype none

interface uart_trx_result_if;
    logic       valid;
    logic       ready;
    logic       line_out;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_frame_error;
    logic       send_dropped;

    modport source (output valid, line_out, rx_valid, rx_data, rx_frame_error,
                    send_dropped, input ready);
    modport sink   (input valid, line_out, rx_valid, rx_data, rx_frame_error,
                    send_dropped, output ready);
endinterface

`default_nettype wire

### design/uart_trx_transceiver_with_tx_fifo_core.sv
// uart transceiver core: receiver, transmitter, register port and output buffer
//
// channel   role    request carries
// --------  ------  ---------------------------------------------------
// tick      sink    line_in, send_valid, send_byte (one line sample)
// result    source  line_out, rx_valid, rx_data, rx_frame_error, send_dropped
// apb       slave   configuration registers, word per register
//
// one tick request is taken every cycle while tick.ready is high; its result is
// registered at the edge that takes it, in the output register or the skid entry.
// a popped byte reaches the transmit shift register in the cycle after the pop,
// through the queue memory read port, before the start bit ends.
// reset clears all control state at once; the queue memory needs no clearing.
// a two-entry output buffer keeps tick.ready high as a result-side stall begins;
// ready drops only when both entries hold results.
`default_nettype none

module uart_transceiver_with_tx_fifo_core
    import uart_trx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    uart_trx_tick_if.sink          tick,
    uart_trx_result_if.source      result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

`include "assert_macros.svh"

    // configuration registers
    logic [BAUD_W-1:0] baud_reg;
    logic [3:0]        data_bits_reg;
    logic [1:0]        stop_bits_reg;
    logic              par_en_reg;
    logic              par_even_reg;
    cfg_reg_t          cfg_sel;
    logic              cfg_we;

    // receiver state
    phase_t            rx_phase_reg, rx_phase_next;
    logic [BAUD_W-1:0] rx_timer_reg, rx_timer_next;
    logic [7:0]        rx_shift_reg, rx_shift_next;
    logic [3:0]        rx_cnt_reg, rx_cnt_next;
    logic              rx_err_reg, rx_err_next;
    logic              rx_prev_reg;
    logic [7:0]        rx_held_reg, rx_held_next;
    logic              rx_done;
    logic              rx_zero;
    logic [4:0]        rx_cnt_inc;
    logic              rx_last;

    // transmitter state
    phase_t            tx_phase_reg, tx_phase_next;
    logic [BAUD_W-1:0] tx_timer_reg, tx_timer_next;
    logic [7:0]        tx_shift_reg;
    logic [3:0]        tx_cnt_reg, tx_cnt_next;
    logic [1:0]        tx_sc_reg, tx_sc_next;
    logic              tx_line_reg, tx_line_next;
    logic              tx_zero;
    logic [4:0]        tx_cnt_inc;
    logic              tx_last;
    logic [1:0]        tx_sc_inc;
    logic              tx_stop_done;
    logic              tx_pop_ok;
    logic              load_pend_reg;

    // queue link
    txq_req_t          q_req;
    txq_status_t       q_status;
    logic [7:0]        q_rd_data;

    // handshake and output buffer
    logic              acc;
    logic              line;
    logic              drop;
    result_t           res;
    result_t           out_data_reg;
    result_t           skid_data_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    // parity over the configured number of data bits
    function automatic logic tx_parity(input logic [7:0] d, input logic [3:0] nbits,
                                       input logic even);
        logic [7:0] m;
        logic       p;
        for (int i = 0; i < 8; i++)
            m[i] = (4'(i) < nbits);
        p = ^(d & m);
        return even ? p : ~p;
    endfunction

    // register write decode
    assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reg      <= BAUD_W'(1);
            data_bits_reg <= DATA_BITS_MAX;
            stop_bits_reg <= STOP_BITS_MIN;
            par_en_reg    <= 1'b0;
            par_even_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_BAUD:
                    baud_reg <= (pwdata[BAUD_W-1:0] == '0) ? BAUD_W'(1)
                                                            : pwdata[BAUD_W-1:0];
                REG_DATA_BITS:
                    data_bits_reg <= (pwdata[3:0] < DATA_BITS_MIN) ? DATA_BITS_MIN :
                                     (pwdata[3:0] > DATA_BITS_MAX) ? DATA_BITS_MAX :
                                     pwdata[3:0];
                REG_STOP_BITS:
                    stop_bits_reg <= (pwdata[1:0] < STOP_BITS_MIN) ? STOP_BITS_MIN :
                                     (pwdata[1:0] > STOP_BITS_MAX) ? STOP_BITS_MAX :
                                     pwdata[1:0];
                REG_PAR_EN:
                    par_en_reg <= pwdata[0];
                REG_PAR_EVEN:
                    par_even_reg <= pwdata[0];
                default:
                    ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (cfg_sel)
            REG_BAUD:      prdata = APB_DW'(baud_reg);
            REG_DATA_BITS: prdata = APB_DW'(data_bits_reg);
            REG_STOP_BITS: prdata = APB_DW'(stop_bits_reg);
            REG_PAR_EN:    prdata = APB_DW'(par_en_reg);
            REG_PAR_EVEN:  prdata = APB_DW'(par_even_reg);
            default:       prdata = '0;
        endcase
    end

    // tick request and queue control
    assign acc        = tick.valid && tick.ready;
    assign line       = tick.line_in;
    assign drop       = tick.send_valid && q_status.full;
    assign q_req.push = acc && tick.send_valid && !q_status.full;
    assign q_req.push_data = tick.send_byte;
    assign tx_pop_ok  = (tx_phase_reg == PH_IDLE) && (!q_status.empty || q_req.push);
    assign q_req.pop  = acc && tx_pop_ok;

    uart_trx_txq u_txq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (q_req),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // receiver next phase
    assign rx_zero    = (rx_timer_reg == '0);
    assign rx_cnt_inc = {1'b0, rx_cnt_reg} + 5'd1;
    assign rx_last    = (rx_cnt_inc >= {1'b0, data_bits_reg});

    always_comb
    begin
        rx_phase_next = rx_phase_reg;
        unique case (rx_phase_reg)
            PH_IDLE:
                if (rx_prev_reg && !line)
                    rx_phase_next = PH_START;
            PH_START:
                if (rx_zero)
                    rx_phase_next = line ? PH_IDLE : PH_DATA;
            PH_DATA:
                if (rx_zero && rx_last)
                    rx_phase_next = par_en_reg ? PH_PARITY : PH_STOP;
            PH_PARITY:
                if (rx_zero)
                    rx_phase_next = PH_STOP;
            default:
                if (rx_zero)
                    rx_phase_next = PH_IDLE;
        endcase
    end

    // receiver datapath
    always_comb
    begin
        rx_timer_next = rx_timer_reg;
        rx_shift_next = rx_shift_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_err_next   = rx_err_reg;
        rx_held_next  = rx_held_reg;
        rx_done       = 1'b0;
        unique case (rx_phase_reg)
            PH_IDLE:
                if (rx_prev_reg && !line)
                begin
                    rx_timer_next = baud_reg >> 1;
                    rx_shift_next = '0;
                    rx_cnt_next   = '0;
                    rx_err_next   = 1'b0;
                end
            PH_START:
                if (!rx_zero)
                    rx_timer_next = rx_timer_reg - 1'b1;
                else if (!line)
                    rx_timer_next = baud_reg;
            PH_DATA:
                if (!rx_zero)
                    rx_timer_next = rx_timer_reg - 1'b1;
                else
                begin
                    if (line)
                        rx_shift_next[rx_cnt_reg[2:0]] = 1'b1;
                    rx_cnt_next   = rx_cnt_inc[3:0];
                    rx_timer_next = baud_reg;
                end
            PH_PARITY:
                if (!rx_zero)
                    rx_timer_next = rx_timer_reg - 1'b1;
                else
                    rx_timer_next = baud_reg;
            default:
                if (!rx_zero)
                    rx_timer_next = rx_timer_reg - 1'b1;
                else
                begin
                    if (!line)
                        rx_err_next = 1'b1;
                    rx_held_next = rx_shift_reg;
                    rx_done      = 1'b1;
                end
        endcase
    end

    // transmitter next phase
    assign tx_zero      = (tx_timer_reg == '0);
    assign tx_cnt_inc   = {1'b0, tx_cnt_reg} + 5'd1;
    assign tx_last      = (tx_cnt_inc >= {1'b0, data_bits_reg});
    assign tx_sc_inc    = tx_sc_reg + 2'd1;
    assign tx_stop_done = (tx_sc_inc >= stop_bits_reg);

    always_comb
    begin
        tx_phase_next = tx_phase_reg;
        unique case (tx_phase_reg)
            PH_IDLE:
                if (tx_pop_ok)
                    tx_phase_next = PH_START;
            PH_START:
                if (tx_zero)
                    tx_phase_next = PH_DATA;
            PH_DATA:
                if (tx_zero && tx_last)
                    tx_phase_next = par_en_reg ? PH_PARITY : PH_STOP;
            PH_PARITY:
                if (tx_zero)
                    tx_phase_next = PH_STOP;
            default:
                if (tx_zero && tx_stop_done)
                    tx_phase_next = PH_IDLE;
        endcase
    end

    // transmitter datapath and line level
    always_comb
    begin
        tx_timer_next = tx_timer_reg;
        tx_cnt_next   = tx_cnt_reg;
        tx_sc_next    = tx_sc_reg;
        tx_line_next  = tx_line_reg;
        unique case (tx_phase_reg)
            PH_IDLE:
                if (tx_pop_ok)
                begin
                    tx_timer_next = baud_reg;
                    tx_line_next  = 1'b0;
                    tx_cnt_next   = '0;
                end
            PH_START:
                if (!tx_zero)
                    tx_timer_next = tx_timer_reg - 1'b1;
                else
                begin
                    tx_line_next  = tx_shift_reg[0];
                    tx_timer_next = baud_reg;
                end
            PH_DATA:
                if (!tx_zero)
                    tx_timer_next = tx_timer_reg - 1'b1;
                else
                begin
                    tx_cnt_next = tx_cnt_inc[3:0];
                    if (tx_last)
                    begin
                        if (par_en_reg)
                            tx_line_next = tx_parity(tx_shift_reg, data_bits_reg,
                                                     par_even_reg);
                        else
                        begin
                            tx_line_next = 1'b1;
                            tx_sc_next   = '0;
                        end
                    end
                    else
                        tx_line_next = tx_shift_reg[tx_cnt_inc[2:0]];
                    tx_timer_next = baud_reg;
                end
            PH_PARITY:
                if (!tx_zero)
                    tx_timer_next = tx_timer_reg - 1'b1;
                else
                begin
                    tx_line_next  = 1'b1;
                    tx_sc_next    = '0;
                    tx_timer_next = baud_reg;
                end
            default:
                if (!tx_zero)
                    tx_timer_next = tx_timer_reg - 1'b1;
                else
                begin
                    tx_sc_next = tx_sc_inc;
                    if (tx_stop_done)
                        tx_line_next = 1'b1;
                    else
                        tx_timer_next = baud_reg;
                end
        endcase
    end

    // frame state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase_reg <= PH_IDLE;
            rx_timer_reg <= '0;
            rx_shift_reg <= '0;
            rx_cnt_reg   <= '0;
            rx_err_reg   <= 1'b0;
            rx_prev_reg  <= 1'b1;
            rx_held_reg  <= '0;
            tx_phase_reg <= PH_IDLE;
            tx_timer_reg <= '0;
            tx_cnt_reg   <= '0;
            tx_sc_reg    <= '0;
            tx_line_reg  <= 1'b1;
        end
        else if (acc)
        begin
            rx_phase_reg <= rx_phase_next;
            rx_timer_reg <= rx_timer_next;
            rx_shift_reg <= rx_shift_next;
            rx_cnt_reg   <= rx_cnt_next;
            rx_err_reg   <= rx_err_next;
            rx_prev_reg  <= line;
            rx_held_reg  <= rx_held_next;
            tx_phase_reg <= tx_phase_next;
            tx_timer_reg <= tx_timer_next;
            tx_cnt_reg   <= tx_cnt_next;
            tx_sc_reg    <= tx_sc_next;
            tx_line_reg  <= tx_line_next;
        end
    end

    // shift register load from the queue read port, in the cycle after the pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pend_reg <= 1'b0;
            tx_shift_reg  <= '0;
        end
        else
        begin
            load_pend_reg <= q_req.pop;
            if (load_pend_reg)
                tx_shift_reg <= q_rd_data;
        end
    end

    // result of the current tick
    assign res.line_out       = tx_line_next;
    assign res.rx_valid       = rx_done;
    assign res.rx_data        = rx_held_next;
    assign res.rx_frame_error = rx_err_next;
    assign res.send_dropped   = drop;

    // output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
            out_valid_reg <= acc;
        else if (acc)
            skid_valid_reg <= 1'b1;
    end

    // output buffer data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result.ready)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (acc)
                out_data_reg <= res;
        end
        else if (acc)
            skid_data_reg <= res;
    end

    // channel outputs
    assign tick.ready            = !skid_valid_reg;
    assign result.valid          = out_valid_reg;
    assign result.line_out       = out_data_reg.line_out;
    assign result.rx_valid       = out_data_reg.rx_valid;
    assign result.rx_data        = out_data_reg.rx_data;
    assign result.rx_frame_error = out_data_reg.rx_frame_error;
    assign result.send_dropped   = out_data_reg.send_dropped;

    // checks
    `CHK_IMPLY(a_skid_behind_head, clk, rst_n, skid_valid_reg, out_valid_reg)
    `CHK_IMPLY(a_shift_loaded, clk, rst_n, tx_phase_reg == PH_DATA, !load_pend_reg)
    `CHK_NEXT(a_pop_starts_frame, clk, rst_n, q_req.pop, tx_phase_reg == PH_START && !tx_line_reg)

endmodule

`default_nettype wire

### design/uart_trx_txq.sv
// transmit byte queue: synchronous memory with pointers and write-to-read bypass
`default_nettype none

module uart_trx_txq
    import uart_trx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire txq_req_t    req,
    output logic [7:0]       rd_data,
    output txq_status_t      status
);

    logic [7:0]        mem [TXQ_DEPTH];
    logic [7:0]        mem_rd_reg;
    logic [7:0]        fwd_data_reg;
    logic              fwd_sel_reg;
    logic [TXQ_AW-1:0] head_reg;
    logic [TXQ_AW-1:0] tail_reg;
    logic [TXQ_CW-1:0] count_reg;
    logic [TXQ_AW-1:0] head_next;
    logic [TXQ_AW-1:0] tail_next;
    logic [TXQ_CW-1:0] count_next;

    // pointer wrap
    function automatic logic [TXQ_AW-1:0] ptr_inc(input logic [TXQ_AW-1:0] p);
        logic [TXQ_AW-1:0] r;
        if (p == TXQ_AW'(TXQ_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // memory: one write port at the tail, one registered read port at the head
    always_ff @(posedge clk)
    begin
        if (req.push)
            mem[tail_reg] <= req.push_data;
        if (req.pop)
            mem_rd_reg <= mem[head_reg];
    end

    // bypass data for a pop of the byte written in the same cycle
    always_ff @(posedge clk)
    begin
        if (req.pop)
            fwd_data_reg <= req.push_data;
    end

    // pointer and count next values
    always_comb
    begin
        head_next  = req.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next  = req.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        case ({req.push, req.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers, count and bypass select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (req.pop)
                fwd_sel_reg <= req.push && (tail_reg == head_reg);
        end
    end

    // read data and status
    assign rd_data      = fwd_sel_reg ? fwd_data_reg : mem_rd_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == TXQ_CW'(TXQ_DEPTH));

endmodule

`default_nettype wire

### bench/uart_trx_tb_pkg.sv
// per-tick line predictor and status checker for the uart transceiver bench
`default_nettype none

package uart_trx_tb_pkg;

    import uart_trx_pkg::*;

    class uart_line_tracker;

        // character format as the block holds it
        logic [23:0] baud;
        logic [3:0]  dbits;
        logic [1:0]  sbits;
        logic        par_en;
        logic        par_even;

        // receiver
        phase_t      rx_ph;
        logic [23:0] rx_tmr;
        logic [7:0]  rx_sh;
        logic [3:0]  rx_cnt;
        logic        rx_err;
        logic        rx_prev;
        logic [7:0]  rx_held;

        // transmitter and its queue
        phase_t      tx_ph;
        logic [23:0] tx_tmr;
        logic [7:0]  tx_sh;
        logic [3:0]  tx_cnt;
        logic [1:0]  tx_stops;
        logic        tx_ln;
        logic [7:0]  send_mem [TXQ_DEPTH];
        int          q_head;
        int          q_tail;
        int          q_count;

        // line status still owed by the block, oldest first
        result_t     line_status_q [$];

        int errors;
        int ticks;
        int checked;
        int chars;
        int frame_errs;
        int offers;
        int drops;

        function new();
            baud     = 24'd1;
            dbits    = 4'd8;
            sbits    = 2'd1;
            par_en   = 1'b0;
            par_even = 1'b0;
            rx_ph    = PH_IDLE;
            rx_tmr   = '0;
            rx_sh    = '0;
            rx_cnt   = '0;
            rx_err   = 1'b0;
            rx_prev  = 1'b1;
            rx_held  = '0;
            tx_ph    = PH_IDLE;
            tx_tmr   = '0;
            tx_sh    = '0;
            tx_cnt   = '0;
            tx_stops = '0;
            tx_ln    = 1'b1;
            q_head   = 0;
            q_tail   = 0;
            q_count  = 0;
            errors   = 0;
            ticks    = 0;
            checked  = 0;
            chars    = 0;
            frame_errs = 0;
            offers   = 0;
            drops    = 0;
        endfunction

        // register write, out of range values clamp as the block does
        function void write_reg(cfg_reg_t r, logic [31:0] v);
            case (r)
                REG_BAUD:
                    baud = (v[23:0] == 24'd0) ? 24'd1 : v[23:0];
                REG_DATA_BITS:
                    dbits = (v[3:0] < DATA_BITS_MIN) ? DATA_BITS_MIN :
                            (v[3:0] > DATA_BITS_MAX) ? DATA_BITS_MAX : v[3:0];
                REG_STOP_BITS:
                    sbits = (v[1:0] < STOP_BITS_MIN) ? STOP_BITS_MIN :
                            (v[1:0] > STOP_BITS_MAX) ? STOP_BITS_MAX : v[1:0];
                REG_PAR_EN:
                    par_en = v[0];
                REG_PAR_EVEN:
                    par_even = v[0];
                default: ;
            endcase
        endfunction

        // receiver, one tick; returns 1 when a character completes
        function bit rx_tick(logic ln);
            bit done;
            done = 1'b0;
            case (rx_ph)
                PH_IDLE:
                    if (rx_prev && !ln) begin
                        rx_ph  = PH_START;
                        rx_tmr = baud >> 1;
                        rx_sh  = '0;
                        rx_cnt = '0;
                        rx_err = 1'b0;
                    end
                PH_START:
                    if (rx_tmr != 0) rx_tmr = rx_tmr - 24'd1;
                    else if (ln) rx_ph = PH_IDLE;
                    else begin
                        rx_ph  = PH_DATA;
                        rx_tmr = baud;
                    end
                PH_DATA:
                    if (rx_tmr != 0) rx_tmr = rx_tmr - 24'd1;
                    else begin
                        if (ln) rx_sh[rx_cnt[2:0]] = 1'b1;
                        rx_cnt = rx_cnt + 4'd1;
                        if (rx_cnt >= dbits) rx_ph = par_en ? PH_PARITY : PH_STOP;
                        rx_tmr = baud;
                    end
                PH_PARITY:
                    if (rx_tmr != 0) rx_tmr = rx_tmr - 24'd1;
                    else begin
                        rx_ph  = PH_STOP;
                        rx_tmr = baud;
                    end
                default:
                    if (rx_tmr != 0) rx_tmr = rx_tmr - 24'd1;
                    else begin
                        if (!ln) rx_err = 1'b1;
                        rx_held = rx_sh;
                        done    = 1'b1;
                        rx_ph   = PH_IDLE;
                    end
            endcase
            rx_prev = ln;
            return done;
        endfunction

        // transmitter, one tick
        function void tx_tick();
            logic ones;
            case (tx_ph)
                PH_IDLE:
                    if (q_count > 0) begin
                        tx_sh   = send_mem[q_head];
                        q_head  = (q_head + 1) % TXQ_DEPTH;
                        q_count = q_count - 1;
                        tx_ph   = PH_START;
                        tx_tmr  = baud;
                        tx_ln   = 1'b0;
                        tx_cnt  = '0;
                    end
                PH_START:
                    if (tx_tmr != 0) tx_tmr = tx_tmr - 24'd1;
                    else begin
                        tx_ph  = PH_DATA;
                        tx_ln  = tx_sh[0];
                        tx_tmr = baud;
                    end
                PH_DATA:
                    if (tx_tmr != 0) tx_tmr = tx_tmr - 24'd1;
                    else begin
                        tx_cnt = tx_cnt + 4'd1;
                        if (tx_cnt >= dbits) begin
                            if (par_en) begin
                                tx_ph = PH_PARITY;
                                ones  = 1'b0;
                                for (int i = 0; i < 8; i++)
                                    if (i < dbits) ones = ones ^ tx_sh[i];
                                tx_ln = par_even ? ones : ~ones;
                            end
                            else begin
                                tx_ph    = PH_STOP;
                                tx_ln    = 1'b1;
                                tx_stops = '0;
                            end
                        end
                        else begin
                            tx_ln = tx_sh[tx_cnt[2:0]];
                        end
                        tx_tmr = baud;
                    end
                PH_PARITY:
                    if (tx_tmr != 0) tx_tmr = tx_tmr - 24'd1;
                    else begin
                        tx_ph    = PH_STOP;
                        tx_ln    = 1'b1;
                        tx_stops = '0;
                        tx_tmr   = baud;
                    end
                default:
                    if (tx_tmr != 0) tx_tmr = tx_tmr - 24'd1;
                    else begin
                        tx_stops = tx_stops + 2'd1;
                        if (tx_stops >= sbits) begin
                            tx_ph = PH_IDLE;
                            tx_ln = 1'b1;
                        end
                        else begin
                            tx_tmr = baud;
                        end
                    end
            endcase
        endfunction

        // accepted tick request: queue the byte, step both sides, owe the status
        function void take_tick(logic ln, logic sv, logic [7:0] b);
            result_t st;
            bit      drop;
            bit      done;
            drop = 1'b0;
            if (sv) begin
                offers++;
                if (q_count >= TXQ_DEPTH) begin
                    drop = 1'b1;
                    drops++;
                end
                else begin
                    send_mem[q_tail] = b;
                    q_tail  = (q_tail + 1) % TXQ_DEPTH;
                    q_count = q_count + 1;
                end
            end
            done = rx_tick(ln);
            tx_tick();
            if (done) begin
                chars++;
                if (rx_err) frame_errs++;
            end
            st.line_out       = tx_ln;
            st.rx_valid       = done;
            st.rx_data        = rx_held;
            st.rx_frame_error = rx_err;
            st.send_dropped   = drop;
            line_status_q.insert(line_status_q.size(), st);
            ticks++;
        endfunction

        function bit line_quiet();
            return rx_ph == PH_IDLE && tx_ph == PH_IDLE && q_count == 0;
        endfunction

        function int owed();
            return line_status_q.size();
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 20)
                $display("mismatch at result %0d: %s got %0h expected %0h",
                         checked, what, got, want);
        endtask

        // compare one accepted result request with the oldest owed status
        task match_status(result_t got);
            result_t want;
            if (line_status_q.size() == 0) begin
                report("result with nothing owed", 1, 0);
            end
            else begin
                want = line_status_q.pop_front();
                if (got.line_out !== want.line_out)
                    report("line_out", int'(got.line_out), int'(want.line_out));
                if (got.rx_valid !== want.rx_valid)
                    report("rx_valid", int'(got.rx_valid), int'(want.rx_valid));
                if (got.rx_data !== want.rx_data)
                    report("rx_data", int'(got.rx_data), int'(want.rx_data));
                if (got.rx_frame_error !== want.rx_frame_error)
                    report("rx_frame_error", int'(got.rx_frame_error),
                           int'(want.rx_frame_error));
                if (got.send_dropped !== want.send_dropped)
                    report("send_dropped", int'(got.send_dropped),
                           int'(want.send_dropped));
            end
            checked++;
        endtask

    endclass

endpackage

`default_nettype wire

### bench/tb.sv
// top of the uart transceiver bench: clock, reset, drivers and run control
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import uart_trx_pkg::*;
    import uart_trx_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 150;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    uart_trx_tick_if   tick_ch ();
    uart_trx_result_if res_ch ();

    uart_line_tracker tracker;

    bit calm;
    int offer_permille;
    int long_hold_asks;
    int long_hold_seen;
    int hold_left;
    int cycles;

    uart_transceiver_with_tx_fifo_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("uart_transceiver_with_tx_fifo_core test failed");
            $finish;
        end
    end

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall length
    function automatic int pick_hold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // result side ready, with random stalls and the occasional long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (long_hold_asks != long_hold_seen)
            begin
                long_hold_seen = long_hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left == 0 && !calm && $urandom_range(0, 99) < 20)
                hold_left = pick_hold();
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.line_out       = res_ch.line_out;
            got.rx_valid       = res_ch.rx_valid;
            got.rx_data        = res_ch.rx_data;
            got.rx_frame_error = res_ch.rx_frame_error;
            got.send_dropped   = res_ch.send_dropped;
            tracker.match_status(got);
        end
    end

    // offer one tick request and wait for it to be taken
    task automatic send_tick(input logic ln, input logic sv, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.line_in    <= ln;
        tick_ch.send_valid <= sv;
        tick_ch.send_byte  <= b;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        tracker.take_tick(ln, sv, b);
    endtask

    // line tick with a random byte offered at the current rate
    task automatic line_tick(input logic ln);
        logic       sv;
        logic [7:0] b;
        sv = ($urandom_range(0, 999) < offer_permille);
        b  = 8'($urandom_range(0, 255));
        send_tick(ln, sv, b);
    endtask

    // hold the line at one level for a number of ticks
    task automatic hold_line(input logic ln, input int n);
        repeat (n) line_tick(ln);
    endtask

    // one serial character on the receive line
    task automatic rx_frame(input logic [7:0] data, input int nbits, input bit stop_ok,
                            input int per);
        hold_line(1'b0, per);
        for (int i = 0; i < nbits; i++)
            hold_line(data[i], per);
        if (tracker.par_en)
            hold_line(1'($urandom_range(0, 1)), per);
        hold_line(stop_ok, per);
        hold_line(1'b1, stop_ok ? $urandom_range(1, per) : per);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (tracker.owed() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // idle line ticks until receiver and transmitter are both at rest
    task automatic drain_line();
        while (!tracker.line_quiet())
            send_tick(1'b1, 1'b0, 8'h00);
    endtask

    // register write: setup then access, then the bus returns to idle
    task automatic apb_write(input cfg_reg_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        tracker.write_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_format(input logic [31:0] baud, input logic [31:0] dbits,
                                input logic [31:0] sbits, input logic [31:0] pen,
                                input logic [31:0] peven);
        wait_drained();
        apb_write(REG_BAUD, baud);
        apb_write(REG_DATA_BITS, dbits);
        apb_write(REG_STOP_BITS, sbits);
        apb_write(REG_PAR_EN, pen);
        apb_write(REG_PAR_EVEN, peven);
    endtask

    // random line traffic: mostly clean characters, some broken ones and noise
    task automatic run_random(input int n);
        int start;
        int r;
        int per;
        int nbits;
        start = tracker.ticks;
        while (tracker.ticks - start < n)
        begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            per = int'(tracker.baud) + 1;
            // now and then a character a tick off the nominal rate
            if ($urandom_range(0, 9) == 0)
                per = (per > 1 && $urandom_range(0, 1)) ? per - 1 : per + 1;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                nbits = ($urandom_range(0, 99) < 85) ? int'(tracker.dbits)
                                                     : $urandom_range(5, 8);
                rx_frame(8'($urandom_range(0, 255)), nbits,
                         $urandom_range(0, 99) < 85, per);
            end
            else if (r < 80)
            begin
                // false start: back high before the start bit is checked
                hold_line(1'b0, $urandom_range(1, int'(tracker.baud >> 1) + 1));
                hold_line(1'b1, $urandom_range(1, per));
            end
            else if (r < 90)
            begin
                repeat ($urandom_range(1, 8)) line_tick(1'($urandom_range(0, 1)));
                hold_line(1'b1, $urandom_range(1, 4));
            end
            else
            begin
                hold_line(1'b1, $urandom_range(1, 20));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        tick_ch.valid      = 1'b0;
        tick_ch.line_in    = 1'b1;
        tick_ch.send_valid = 1'b0;
        tick_ch.send_byte  = 8'h00;
        res_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        calm               = 1'b1;
        offer_permille     = 0;
        long_hold_asks     = 0;
        long_hold_seen     = 0;
        cycles             = 0;
        tracker            = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, false start, character with a low stop bit
        send_tick(1'b1, 1'b1, 8'h00);
        send_tick(1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 8'h00);
        rx_frame(8'hA5, 8, 1'b0, 2);

        // zero bit period, data and stop bits above and below range
        calm = 1'b0;
        apply_format(32'd0, 32'd15, 32'd0, 32'd0, 32'd0);
        offer_permille = 150;
        run_random(300);

        apply_format(32'd1, 32'd5, 32'd2, 32'd1, 32'd1);
        offer_permille = 40;
        run_random(250);

        // largest bit period, only with both sides at rest
        offer_permille = 0;
        drain_line();
        wait_drained();
        apb_write(REG_BAUD, 32'h00FF_FFFF);
        repeat (20) send_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));

        // receiver holds off while ticks keep coming
        apply_format(32'd3, 32'd7, 32'd3, 32'd1, 32'd0);
        offer_permille = 60;
        run_random(100);
        long_hold_asks++;
        run_random(200);

        apply_format(32'd2, 32'd4, 32'd1, 32'd0, 32'd1);
        offer_permille = 20;
        run_random(250);

        apply_format(32'd6, 32'd6, 32'd2, 32'd1, 32'd1);
        offer_permille = 20;
        run_random(400);

        // heavy offering so the send queue fills and drops
        apply_format(32'd1, 32'd8, 32'd1, 32'd0, 32'd0);
        offer_permille = 300;
        run_random(300);

        wait_drained();
        repeat (16) @(posedge clk);
        if (tracker.owed() != 0)
            tracker.report("results never arrived", tracker.owed(), 0);

        $display("covered %0d line ticks, %0d characters received, %0d with frame errors",
                 tracker.ticks, tracker.chars, tracker.frame_errs);
        $display("%0d bytes offered for sending, %0d dropped on a full queue, %0d mismatches",
                 tracker.offers, tracker.drops, tracker.errors);
        if (tracker.errors == 0)
            $display("uart_transceiver_with_tx_fifo_core test passed");
        else
            $display("uart_transceiver_with_tx_fifo_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
